/* hw/rtl/swfr_pkg.sv */
package swfr_pkg;

  // Frame layout
  localparam int MAX_PAYLOAD  = 1024;
  localparam int HEADER_BYTES = 9;
  localparam int CHECK_BYTES  = 4;
  localparam int MIN_LEN      = HEADER_BYTES + CHECK_BYTES;
  localparam int POS_W        = 11;
  localparam int POS_MAX      = (1 << POS_W) - 1;

  // Reflected CRC-32
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  // Room left for the request in the input stage and the one being taken
  localparam int FIFO_ROOM  = FIFO_DEPTH - 4;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [7:0]       payload_byte;
    logic [7:0]       ack_seq;
    logic             crc_ok;
    logic             accepted;
    logic [POS_W-1:0] payload_len;
    logic             frame_bad;
    logic             transfer_done;
    logic             last;
  } result_t;

  // Results produced by one byte, r0 first
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  // One byte through the reflected CRC, eight shift steps
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

/* hw/rtl/swfr_core.sv */
module swfr_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_acc,
  input  logic [7:0]     in_byte,
  input  logic           in_end,
  output swfr_pkg::push_t push
);
  import swfr_pkg::*;

  // Input stage
  logic             stg_valid_r;
  logic [7:0]       stg_byte_r;
  logic             stg_end_r;

  // Frame state
  logic [7:0]       exp_r, exp_nxt;
  logic [7:0]       fseq_r, fseq_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       tail_r [CHECK_BYTES];
  logic [7:0]       tail_nxt [CHECK_BYTES];

  logic [31:0]      crc_upd;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] plen_raw;
  logic [POS_W-1:0] plen;
  logic [31:0]      word;
  logic             emit_pl;
  logic             crc_ok;
  logic             runt;
  logic             oversize;
  logic             bad;
  logic             acc;
  result_t          pl_res;
  result_t          vd_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_byte_r <= in_byte;
      stg_end_r  <= in_end;
    end
  end

  // Frame processing for the staged byte
  always_comb begin
    fseq_nxt = (pos_r == '0) ? stg_byte_r : fseq_r;
    crc_upd  = (pos_r >= POS_W'(CHECK_BYTES)) ? crc_byte(crc_r, tail_r[0]) : crc_r;
    emit_pl  = (pos_r >= POS_W'(MIN_LEN)) && (pos_r < POS_W'(MIN_LEN + MAX_PAYLOAD));
    pos_inc  = (pos_r != POS_W'(POS_MAX)) ? pos_r + POS_W'(1) : pos_r;

    // check word: last four bytes, little-endian
    word     = {stg_byte_r, tail_r[3], tail_r[2], tail_r[1]};
    crc_ok   = (pos_inc >= POS_W'(CHECK_BYTES)) && ((crc_upd ^ CRC_INIT) == word);
    runt     = pos_inc < POS_W'(MIN_LEN);
    plen_raw = runt ? '0 : pos_inc - POS_W'(MIN_LEN);
    oversize = plen_raw > POS_W'(MAX_PAYLOAD);
    plen     = oversize ? POS_W'(MAX_PAYLOAD) : plen_raw;
    bad      = runt || oversize;
    acc      = crc_ok && !bad && (fseq_nxt == exp_r);

    pl_res              = '0;
    pl_res.kind         = KIND_PAYLOAD;
    pl_res.payload_byte = tail_r[0];
    pl_res.last         = !stg_end_r;

    vd_res               = '0;
    vd_res.kind          = KIND_VERDICT;
    vd_res.ack_seq       = acc ? fseq_nxt + 8'd1 : exp_r;
    vd_res.crc_ok        = crc_ok;
    vd_res.accepted      = acc;
    vd_res.payload_len   = plen;
    vd_res.frame_bad     = bad;
    vd_res.transfer_done = acc && (plen < POS_W'(MAX_PAYLOAD));
    vd_res.last          = 1'b1;

    push = '0;
    if (stg_valid_r) begin
      if (emit_pl) begin
        push.r0  = pl_res;
        push.r1  = vd_res;
        push.cnt = stg_end_r ? 2'd2 : 2'd1;
      end else begin
        push.r0  = vd_res;
        push.cnt = stg_end_r ? 2'd1 : 2'd0;
      end
    end

    // state update, frame end returns to the idle frame
    exp_nxt = exp_r;
    crc_nxt = crc_r;
    pos_nxt = pos_r;
    for (int i = 0; i < CHECK_BYTES; i++) begin
      tail_nxt[i] = tail_r[i];
    end
    if (stg_valid_r) begin
      if (stg_end_r) begin
        exp_nxt = vd_res.ack_seq;
        crc_nxt = CRC_INIT;
        pos_nxt = '0;
        for (int i = 0; i < CHECK_BYTES; i++) begin
          tail_nxt[i] = 8'd0;
        end
      end else begin
        crc_nxt = crc_upd;
        pos_nxt = pos_inc;
        for (int i = 0; i < CHECK_BYTES - 1; i++) begin
          tail_nxt[i] = tail_r[i+1];
        end
        tail_nxt[CHECK_BYTES-1] = stg_byte_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= 8'd0;
      fseq_r <= 8'd0;
      crc_r  <= CRC_INIT;
      pos_r  <= '0;
      for (int i = 0; i < CHECK_BYTES; i++) begin
        tail_r[i] <= 8'd0;
      end
    end else begin
      exp_r <= exp_nxt;
      crc_r <= crc_nxt;
      pos_r <= pos_nxt;
      if (stg_valid_r) begin
        fseq_r <= fseq_nxt;
      end
      for (int i = 0; i < CHECK_BYTES; i++) begin
        tail_r[i] <= tail_nxt[i];
      end
    end
  end

  // Expected sequence moves only on a frame end
  a_exp_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r != $past(exp_r)) |-> $past(stg_valid_r && stg_end_r))
    else $error("expected sequence changed outside a frame end");

  // A frame end leaves a cleared frame
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid_r && stg_end_r) |=> (pos_r == '0) && (crc_r == CRC_INIT))
    else $error("frame state not cleared after frame end");

  // Two results only as payload then verdict
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (push.r0.kind == KIND_PAYLOAD) && (push.r1.kind == KIND_VERDICT))
    else $error("result pair out of order");

endmodule

/* hw/rtl/swfr_out_fifo.sv */
module swfr_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  swfr_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  output swfr_pkg::result_t out_res,
  input  logic              out_ready
);
  import swfr_pkg::*;

  result_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               pop;
  logic [FIFO_AW-1:0] wr_ptr_p1;

  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign room      = (count_r <= (FIFO_AW+1)'(FIFO_ROOM));
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + FIFO_AW'(1);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (FIFO_AW+1)'(push.cnt) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, up to two writes a cycle
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ((FIFO_AW+2)'(count_r) + (FIFO_AW+2)'(push.cnt)) <=
      (FIFO_AW+2)'(FIFO_DEPTH) + (FIFO_AW+2)'(pop))
    else $error("result queue overflow");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue count out of range");

  a_pop_moves_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (rd_ptr_r == $past(rd_ptr_r) + FIFO_AW'(1)))
    else $error("read pointer did not advance on pop");

endmodule

/* hw/rtl/stop_and_wait_frame_receiver.sv */
// Path: a byte's results pass the input stage register and then the result queue before they are offered.
// Throughput: one byte per cycle while in_tready is high; a frame-end byte with a payload byte yields two results,
//   which drain one per cycle while out_tready is high, through an eight-entry result queue.
// in_tready drops while the queue holds more than four results.
// Reset: synchronous, active low; clears sequence, CRC, byte count, delay line and queue.
module stop_and_wait_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] payload_byte, [15:8] ack_seq, [16] crc_ok,
                                  // [17] accepted, [28:18] payload_len, [29] frame_bad,
                                  // [30] transfer_done, [31] zero
  output logic        out_tuser,  // kind
  output logic        out_tlast   // last
);
  import swfr_pkg::*;

  push_t   push;
  result_t res;
  logic    room;
  logic    in_acc;

  assign in_tready = room;
  assign in_acc    = in_tvalid && in_tready;

  swfr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_byte (in_tdata),
    .in_end  (in_tlast),
    .push    (push)
  );

  swfr_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_res   (res),
    .out_ready (out_tready)
  );

  // Pack the result fields
  assign out_tdata = {1'b0, res.transfer_done, res.frame_bad, res.payload_len,
                      res.accepted, res.crc_ok, res.ack_seq, res.payload_byte};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

/* bench/tb_stop_and_wait_frame_receiver.sv */
`timescale 1ns / 100ps

module tb_stop_and_wait_frame_receiver;
  import swfr_pkg::*;

  // No request moving on either side for this long means the block has hung
  localparam int IDLE_LIMIT = 2000;
  // Input requests over the whole run, directed frames included
  localparam int TOTAL_BYTES = 750;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  // Receiver state as the bench sees it
  logic [7:0]  want_seq;
  logic [7:0]  seq_byte;
  logic [31:0] crc_run;
  int          rx_count;
  logic [7:0]  hold_line [4];

  result_t     due_results [$];
  logic [7:0]  frame_buf [$];
  int          bytes_sent;
  int          fails;
  int          idle_cycles;

  stop_and_wait_frame_receiver u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reflected CRC-32, one bit at a time, LSB first
  function automatic logic [31:0] crc_step8(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0] ^ b[i]}});
    end
    return c;
  endfunction

  function automatic void clear_frame_state();
    crc_run  = CRC_INIT;
    rx_count = 0;
    for (int i = 0; i < 4; i++) begin
      hold_line[i] = 8'h00;
    end
  endfunction

  // Payload forwarding through the four-byte delay and the end-of-frame verdict
  function automatic void judge_byte(input logic [7:0] b, input logic eop);
    int          p;
    int          len;
    int          plen;
    logic [7:0]  leaving;
    logic [31:0] word;
    logic        ok;
    logic        runt;
    logic        oversize;
    logic        bad;
    logic        acc;
    result_t     r;
    p = rx_count;
    if (p == 0) begin
      seq_byte = b;
    end
    // Byte leaving the delay goes into the CRC; payload bytes are forwarded
    if (p >= CHECK_BYTES) begin
      leaving = hold_line[0];
      crc_run = crc_step8(crc_run, leaving);
      if (p - CHECK_BYTES >= HEADER_BYTES &&
          p - CHECK_BYTES - HEADER_BYTES < MAX_PAYLOAD) begin
        r              = '0;
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = leaving;
        r.last         = !eop;
        due_results.push_back(r);
      end
    end
    for (int i = 0; i < 3; i++) begin
      hold_line[i] = hold_line[i + 1];
    end
    hold_line[3] = b;
    if (rx_count < POS_MAX) begin
      rx_count++;
    end
    // Verdict
    if (eop) begin
      len      = rx_count;
      word     = {hold_line[3], hold_line[2], hold_line[1], hold_line[0]};
      ok       = (len >= CHECK_BYTES) && ((crc_run ^ CRC_INIT) == word);
      runt     = len < MIN_LEN;
      plen     = runt ? 0 : len - MIN_LEN;
      oversize = plen > MAX_PAYLOAD;
      bad      = runt || oversize;
      if (oversize) begin
        plen = MAX_PAYLOAD;
      end
      acc = ok && !bad && (seq_byte == want_seq);
      if (acc) begin
        want_seq = seq_byte + 8'd1;
      end
      r               = '0;
      r.kind          = KIND_VERDICT;
      r.ack_seq       = want_seq;
      r.crc_ok        = ok;
      r.accepted      = acc;
      r.payload_len   = plen[POS_W-1:0];
      r.frame_bad     = bad;
      r.transfer_done = acc && (plen < MAX_PAYLOAD);
      r.last          = 1'b1;
      due_results.push_back(r);
      clear_frame_state();
    end
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  // One request on the input side; valid stays up when the next follows at once
  task automatic send_byte(input logic [7:0] b, input logic eop, input logic no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eop;
    do @(posedge clk); while (in_tready !== 1'b1);
    judge_byte(b, eop);
    bytes_sent++;
  endtask

  // Sequence byte then body_len-1 random bytes
  function automatic void start_frame(input logic [7:0] seq, input int body_len);
    frame_buf.delete();
    frame_buf.push_back(seq);
    for (int i = 1; i < body_len; i++) begin
      frame_buf.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Append the little-endian check word
  function automatic void seal_frame();
    logic [31:0] c;
    c = CRC_INIT;
    foreach (frame_buf[i]) begin
      c = crc_step8(c, frame_buf[i]);
    end
    c = ~c;
    for (int k = 0; k < 4; k++) begin
      frame_buf.push_back(c[8*k +: 8]);
    end
  endfunction

  function automatic void flip_random_bit();
    int idx;
    idx = $urandom_range(0, frame_buf.size() - 1);
    frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
  endfunction

  task automatic push_frame();
    logic burst;
    burst = ($urandom_range(0, 3) == 0);
    foreach (frame_buf[i]) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1, burst);
    end
  endtask

  task automatic good_frame(input int plen);
    start_frame(want_seq, HEADER_BYTES + plen);
    seal_frame();
    push_frame();
  endtask

  // Frames too short for header and check word
  task automatic test_runt_frames();
    frame_buf.delete();
    frame_buf.push_back(8'hFF);
    push_frame();
    frame_buf.delete();
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h80);
    frame_buf.push_back(8'h7F);
    push_frame();
    // Check word alone; CRC of nothing is zero, so it matches
    frame_buf.delete();
    repeat (4) frame_buf.push_back(8'h00);
    push_frame();
    // One byte short of an empty frame, with a good check word
    start_frame(want_seq, HEADER_BYTES - 1);
    seal_frame();
    push_frame();
  endtask

  task automatic test_in_order_frames();
    good_frame(0);
    start_frame(want_seq, HEADER_BYTES + 4);
    frame_buf[HEADER_BYTES]     = 8'h00;
    frame_buf[HEADER_BYTES + 1] = 8'hFF;
    frame_buf[HEADER_BYTES + 2] = 8'h55;
    frame_buf[HEADER_BYTES + 3] = 8'hAA;
    seal_frame();
    push_frame();
    // Retransmission of the frame just taken
    start_frame(want_seq - 8'd1, HEADER_BYTES + 2);
    seal_frame();
    push_frame();
  endtask

  task automatic test_corrupt_frames();
    start_frame(want_seq, HEADER_BYTES + 3);
    seal_frame();
    frame_buf[frame_buf.size() - 1] = frame_buf[frame_buf.size() - 1] ^ 8'h80;
    push_frame();
    start_frame(want_seq, HEADER_BYTES + 3);
    seal_frame();
    frame_buf[HEADER_BYTES] = frame_buf[HEADER_BYTES] ^ 8'h01;
    push_frame();
    // Ahead of the expected sequence
    start_frame(want_seq + 8'd2, HEADER_BYTES + 1);
    seal_frame();
    push_frame();
  endtask

  // Mixed frames until the byte budget for the run is used up
  task automatic test_random_traffic();
    int r;
    int n;
    while (bytes_sent < TOTAL_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        good_frame(($urandom_range(0, 4) != 0) ? $urandom_range(0, 24) : $urandom_range(25, 80));
      end else if (r < 73) begin
        start_frame(want_seq, HEADER_BYTES + $urandom_range(0, 20));
        seal_frame();
        flip_random_bit();
        push_frame();
      end else if (r < 80) begin
        // Stale retransmission or a random wrong sequence
        start_frame($urandom_range(0, 1) ? want_seq - 8'd1 :
                    want_seq + 8'($urandom_range(1, 255)),
                    HEADER_BYTES + $urandom_range(0, 16));
        seal_frame();
        push_frame();
      end else if (r < 87) begin
        start_frame(8'($urandom_range(0, 255)), $urandom_range(1, MIN_LEN - 1));
        if ($urandom_range(0, 1) && frame_buf.size() < MIN_LEN - CHECK_BYTES) begin
          seal_frame();
        end
        push_frame();
      end else if (r < 93) begin
        // Cut short or overrun by a few bytes
        start_frame(want_seq, HEADER_BYTES + $urandom_range(0, 16));
        seal_frame();
        if ($urandom_range(0, 1)) begin
          repeat ($urandom_range(1, 6)) void'(frame_buf.pop_back());
        end else begin
          repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom_range(0, 255)));
        end
        push_frame();
      end else begin
        n = $urandom_range(1, 40);
        start_frame(8'($urandom_range(0, 255)), n);
        push_frame();
      end
    end
  endtask

  // Result side back-pressure: free-running spans, random stalls and the odd long one
  initial begin
    int mode;
    int r;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 9);
      repeat ($urandom_range(20, 200)) begin
        if (mode < 3) begin
          out_tready <= 1'b1;
          @(posedge clk);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 70) begin
            out_tready <= 1'b1;
            @(posedge clk);
          end else if (r < 95) begin
            out_tready <= 1'b0;
            @(posedge clk);
          end else begin
            out_tready <= 1'b0;
            repeat ($urandom_range(5, 40)) @(posedge clk);
          end
        end
      end
    end
  end

  // Compare each result with the oldest one due
  function automatic void compare_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing due, expected none, got kind %0b data %h last %0b",
                 $time, out_tuser, out_tdata, out_tlast);
        fails++;
      end else begin
        want = due_results.pop_front();
        compare_field("kind", want.kind, out_tuser);
        compare_field("payload_byte", want.payload_byte, out_tdata[7:0]);
        compare_field("ack_seq", want.ack_seq, out_tdata[15:8]);
        compare_field("crc_ok", want.crc_ok, out_tdata[16]);
        compare_field("accepted", want.accepted, out_tdata[17]);
        compare_field("payload_len", want.payload_len, out_tdata[28:18]);
        compare_field("frame_bad", want.frame_bad, out_tdata[29]);
        compare_field("transfer_done", want.transfer_done, out_tdata[30]);
        compare_field("spare bit", 0, out_tdata[31]);
        compare_field("last", want.last, out_tlast);
      end
    end
  end

  // Hang detection
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tlast   = 1'b0;
    fails      = 0;
    bytes_sent = 0;
    want_seq   = 8'h00;
    seq_byte   = 8'h00;
    clear_frame_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_runt_frames();
    test_in_order_frames();
    test_corrupt_frames();
    test_random_traffic();
    in_tvalid <= 1'b0;

    // Drain, then a few cycles for anything unexpected to show
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
